### sv/assert_macros.svh
// assertion macros used by the heap queue controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge outside reset
`define MHPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define MHPQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/mhpq_pkg.sv
// types, constants and codes of the max heap priority queue
package mhpq_pkg;

   localparam int CAPACITY   = 128;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [1:0] {
      FN_INSERT      = 2'd0,
      FN_REMOVE_MAX  = 2'd1,
      FN_REMOVE_EVEN = 2'd2,
      FN_PEEK        = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } cell_op_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_COMPACT = 2'd1,
      S_FINISH  = 2'd2
   } state_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type           op;
      logic                  append;
      logic [IDX_W-1:0]      app_idx;
      logic [DATA_WIDTH-1:0] bcast;
      logic [CNT_W-1:0]      count;
   } cell_cmd_type;

endpackage

### sv/mhpq_cell.sv
// one cell of the sorted chain: holds one value, largest values toward cell zero
module mhpq_cell (
   input  logic                            clock,
   input  logic [mhpq_pkg::IDX_W-1:0]      cell_idx,
   input  mhpq_pkg::cell_cmd_type          cmd,
   input  logic                            left_ge,
   input  logic [mhpq_pkg::DATA_WIDTH-1:0] left_value,
   input  logic [mhpq_pkg::DATA_WIDTH-1:0] right_value,
   output logic [mhpq_pkg::DATA_WIDTH-1:0] value,
   output logic                            ge
);

   logic [mhpq_pkg::DATA_WIDTH-1:0] value_ff;
   logic [mhpq_pkg::DATA_WIDTH-1:0] value_in;
   logic                            occupied;

   assign occupied = mhpq_pkg::CNT_W'(cell_idx) < cmd.count;
   assign ge       = occupied && ($signed(value_ff) >= $signed(cmd.bcast));
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      unique case (cmd.op)
         mhpq_pkg::CELL_INSERT: begin
            // keep own value, take the new one, or move one place right
            if (ge) begin
               value_in = value_ff;
            end else if (left_ge) begin
               value_in = cmd.bcast;
            end else begin
               value_in = left_value;
            end
         end
         mhpq_pkg::CELL_SHIFT: begin
            if (cmd.append && (cmd.app_idx == cell_idx)) begin
               value_in = cmd.bcast;
            end else begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### sv/mhpq_ctrl.sv
// sequencer: decodes transactions, drives the cell chain and holds the result register
`include "assert_macros.svh"

module mhpq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_func,
   input  logic [31:0]                     req_new_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [31:0]                     rsp_top_value,
   output logic [7:0]                      rsp_entry_count,
   output logic [1:0]                      rsp_status,
   input  logic [mhpq_pkg::DATA_WIDTH-1:0] head_value,
   output mhpq_pkg::cell_cmd_type          cmd
);

   mhpq_pkg::state_type          state_ff, state_in;
   logic [mhpq_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [mhpq_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [mhpq_pkg::CNT_W-1:0]   kept_ff, kept_in;
   mhpq_pkg::status_type         status_ff, status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [31:0]                  top_ff, top_in;
   logic [7:0]                   ecount_ff, ecount_in;
   mhpq_pkg::status_type         rstatus_ff, rstatus_in;

   logic [mhpq_pkg::DATA_WIDTH-1:0]    new_ext;
   logic [mhpq_pkg::DATA_WIDTH+31:0]   new_wide;
   logic [mhpq_pkg::DATA_WIDTH+31:0]   head_wide;
   logic [mhpq_pkg::CNT_W+7:0]         count_wide;
   logic [mhpq_pkg::CNT_W-1:0]         app_pos;
   logic                               keep_head;
   logic                               out_free;
   logic                               accept;

   assign new_wide   = {{mhpq_pkg::DATA_WIDTH{req_new_value[31]}}, req_new_value};
   assign new_ext    = new_wide[mhpq_pkg::DATA_WIDTH-1:0];
   assign head_wide  = {32'b0, head_value};
   assign count_wide = {8'b0, count_ff};
   assign keep_head  = head_value[0];
   assign app_pos    = rem_ff + kept_ff - mhpq_pkg::CNT_W'(1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != mhpq_pkg::S_IDLE);
   assign accept     = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      kept_in      = kept_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      top_in       = top_ff;
      ecount_in    = ecount_ff;
      rstatus_in   = rstatus_ff;
      cmd.op       = mhpq_pkg::CELL_HOLD;
      cmd.append   = 1'b0;
      cmd.app_idx  = app_pos[mhpq_pkg::IDX_W-1:0];
      cmd.bcast    = new_ext;
      cmd.count    = count_ff;
      unique case (state_ff)
         mhpq_pkg::S_IDLE: begin
            if (accept) begin
               status_in = mhpq_pkg::ST_DONE;
               state_in  = mhpq_pkg::S_FINISH;
               unique case (mhpq_pkg::func_type'(req_func))
                  mhpq_pkg::FN_INSERT: begin
                     if (count_ff >= mhpq_pkg::CAP_CNT) begin
                        status_in = mhpq_pkg::ST_FULL;
                     end else begin
                        cmd.op   = mhpq_pkg::CELL_INSERT;
                        count_in = count_ff + mhpq_pkg::CNT_W'(1);
                     end
                  end
                  mhpq_pkg::FN_REMOVE_MAX: begin
                     if (count_ff == '0) begin
                        status_in = mhpq_pkg::ST_EMPTY;
                     end else begin
                        cmd.op   = mhpq_pkg::CELL_SHIFT;
                        count_in = count_ff - mhpq_pkg::CNT_W'(1);
                     end
                  end
                  mhpq_pkg::FN_REMOVE_EVEN: begin
                     if (count_ff == '0) begin
                        status_in = mhpq_pkg::ST_EMPTY;
                     end else begin
                        rem_in   = count_ff;
                        kept_in  = '0;
                        state_in = mhpq_pkg::S_COMPACT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mhpq_pkg::S_COMPACT: begin
            // pop the head and append it behind the kept values when odd
            cmd.op     = mhpq_pkg::CELL_SHIFT;
            cmd.append = keep_head;
            cmd.bcast  = head_value;
            rem_in     = rem_ff - mhpq_pkg::CNT_W'(1);
            kept_in    = kept_ff + mhpq_pkg::CNT_W'(keep_head);
            if (rem_ff == mhpq_pkg::CNT_W'(1)) begin
               count_in = kept_ff + mhpq_pkg::CNT_W'(keep_head);
               state_in = mhpq_pkg::S_FINISH;
            end
         end
         mhpq_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               top_in       = (count_ff != '0) ? head_wide[31:0] : 32'b0;
               ecount_in    = count_wide[7:0];
               rstatus_in   = status_ff;
               state_in     = mhpq_pkg::S_IDLE;
            end
         end
         default: state_in = mhpq_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhpq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      kept_ff    <= kept_in;
      status_ff  <= status_in;
      top_ff     <= top_in;
      ecount_ff  <= ecount_in;
      rstatus_ff <= rstatus_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = top_ff;
   assign rsp_entry_count = ecount_ff;
   assign rsp_status      = rstatus_ff;

   `MHPQ_ASSERT_ALWAYS(a_count_bound, reset || (count_ff <= mhpq_pkg::CAP_CNT),
      "count above capacity")
   `MHPQ_ASSERT(a_compact_span, (state_ff == mhpq_pkg::S_COMPACT) |->
      ((rem_ff != '0) && ((rem_ff + kept_ff) <= mhpq_pkg::CAP_CNT)),
      "compaction span out of range")
   `MHPQ_ASSERT(a_insert_grows, (accept && (req_func == mhpq_pkg::FN_INSERT) &&
      (count_ff < mhpq_pkg::CAP_CNT)) |=> (count_ff == $past(count_ff) + mhpq_pkg::CNT_W'(1)),
      "insert did not grow count")
   `MHPQ_ASSERT(a_finish_issues, ((state_ff == mhpq_pkg::S_FINISH) && out_free) |=>
      (rsp_valid_ff && (state_ff == mhpq_pkg::S_IDLE)), "finished transaction not issued")

endmodule

### sv/max_heap_priority_queue.sv
// max heap priority queue: top level with the cell chain and its sequencer
//
// usage
//   req channel: one transaction carries req_func (insert, remove maximum,
//   remove all even values, peek) and req_new_value (used by insert only)
//   rsp channel: one transaction per request with rsp_top_value (largest
//   stored value, zero when empty), rsp_entry_count and rsp_status
//   (done, empty on removal, insert rejected because full)
//   values are kept sorted in a chain of cells, largest in cell zero
// sequence
//   insert, remove maximum and peek: the request moves the sequencer to its
//   finish step, which loads the result register and raises rsp_valid
//   remove all even values: the compact step first pops every stored value,
//   one pop per cycle, keeping the odd ones, then the finish step follows
//   req_stall is high from accept until the result is loaded
// reset
//   synchronous reset empties the queue and drops any pending result
// receiver stall
//   the result register holds a valid result while rsp_stall is high; a
//   finished request waits in its last step until the register is free
module max_heap_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_new_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_top_value,
   output logic [7:0]  rsp_entry_count,
   output logic [1:0]  rsp_status
);

   // command shared by every cell
   mhpq_pkg::cell_cmd_type cmd;

   // per cell value and compare outputs, one extra value slot past the tail
   logic [mhpq_pkg::DATA_WIDTH-1:0] cell_value [mhpq_pkg::CAPACITY+1];
   logic                            cell_ge    [mhpq_pkg::CAPACITY];

   // nothing lives past the last cell
   assign cell_value[mhpq_pkg::CAPACITY] = '0;

   mhpq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_top_value   (rsp_top_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status),
      .head_value      (cell_value[0]),
      .cmd             (cmd)
   );

   // the chain: each cell talks to its left and right neighbor only
   for (genvar g = 0; g < mhpq_pkg::CAPACITY; g++) begin : g_cell
      logic                            left_ge;
      logic [mhpq_pkg::DATA_WIDTH-1:0] left_value;

      if (g == 0) begin : g_head
         // the head sees a larger-or-equal left, so a new maximum lands here
         assign left_ge    = 1'b1;
         assign left_value = '0;
      end else begin : g_body
         assign left_ge    = cell_ge[g-1];
         assign left_value = cell_value[g-1];
      end

      mhpq_cell u_cell (
         .clock       (clock),
         .cell_idx    (mhpq_pkg::IDX_W'(g)),
         .cmd         (cmd),
         .left_ge     (left_ge),
         .left_value  (left_value),
         .right_value (cell_value[g+1]),
         .value       (cell_value[g]),
         .ge          (cell_ge[g])
      );
   end

endmodule

### bench/tb_top.sv
// self-checking testbench for the max heap priority queue
module tb_top;

   localparam int RANDOM_ITEMS = 500;
   localparam int HOLD_AT      = 60;    // result count at which the long hold-off starts
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 200;   // quiet time after the last result

   typedef struct {
      mhpq_pkg::func_type func;
      logic [31:0]        value;
   } heap_req_type;

   typedef struct {
      logic [31:0]          top;
      logic [7:0]           count;
      mhpq_pkg::status_type status;
   } heap_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = mhpq_pkg::FN_PEEK;
   logic [31:0] req_new_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_top_value;
   logic [7:0]  rsp_entry_count;
   logic [1:0]  rsp_status;

   // stimulus not yet offered, results still expected, and the values the queue should hold
   heap_req_type       pending_ops[$];
   heap_rsp_type       expected_rsp[$];
   logic signed [31:0] heap_vals[$];

   int n_total = 0;
   int n_accepted = 0;
   int rsp_seen = 0;
   int n_errors = 0;
   int n_full = 0;
   int n_empty = 0;
   int peak_count = 0;
   int op_seen[4] = '{0, 0, 0, 0};

   // handshake flags passed from the sampling edge to the driving edge
   bit req_taken = 1'b0;
   bit req_busy = 1'b0;
   bit rsp_taken = 1'b0;
   int req_wait = 0;
   int rsp_wait = 0;

   max_heap_priority_queue dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_top_value   (rsp_top_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      n_errors++;
      $display("mismatch at result %0d: %s got %0h, wanted %0h", rsp_seen, what, got, want);
   endtask

   function automatic int max_index();
      int best;
      best = 0;
      for (int i = 1; i < heap_vals.size(); i++)
         if (heap_vals[i] > heap_vals[best])
            best = i;
      return best;
   endfunction

   // the visible behavior only needs the multiset of stored values
   function automatic heap_rsp_type predict_op(mhpq_pkg::func_type f, logic [31:0] v);
      heap_rsp_type       r;
      logic signed [31:0] odd_vals[$];
      r.status = mhpq_pkg::ST_DONE;
      case (f)
         mhpq_pkg::FN_INSERT: begin
            if (heap_vals.size() >= mhpq_pkg::CAPACITY) begin
               r.status = mhpq_pkg::ST_FULL;
               n_full++;
            end else
               heap_vals.push_back(v);
         end
         mhpq_pkg::FN_REMOVE_MAX: begin
            if (heap_vals.size() == 0) begin
               r.status = mhpq_pkg::ST_EMPTY;
               n_empty++;
            end else
               heap_vals.delete(max_index());
         end
         mhpq_pkg::FN_REMOVE_EVEN: begin
            if (heap_vals.size() == 0) begin
               r.status = mhpq_pkg::ST_EMPTY;
               n_empty++;
            end else begin
               // even means lowest bit clear, negative values included
               foreach (heap_vals[i])
                  if (heap_vals[i][0])
                     odd_vals.push_back(heap_vals[i]);
               heap_vals = odd_vals;
            end
         end
         default: ;
      endcase
      r.count = 8'(heap_vals.size());
      r.top = (heap_vals.size() > 0) ? heap_vals[max_index()] : '0;
      if (heap_vals.size() > peak_count)
         peak_count = heap_vals.size();
      return r;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'($signed($urandom_range(0, 32)) - 16);
         1: return {1'b0, 31'($urandom)};
         2: return {1'b1, 31'($urandom)};
         3: return $urandom_range(0, 3) == 0 ? 32'h7fff_ffff :
                   ($urandom_range(0, 1) ? 32'h8000_0000 : 32'hffff_ffff);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_op(mhpq_pkg::func_type f, logic [31:0] v);
      heap_req_type item;
      item.func = f;
      item.value = v;
      pending_ops.push_back(item);
      n_total++;
   endtask

   // pick an operation: ins_pct percent inserts, removes allowed or not
   task automatic queue_random(int ins_pct, bit allow_remove);
      int                 roll;
      mhpq_pkg::func_type f;
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)
         f = mhpq_pkg::FN_INSERT;
      else if (!allow_remove)
         f = mhpq_pkg::FN_PEEK;
      else begin
         roll = $urandom_range(0, 11);
         f = (roll == 0) ? mhpq_pkg::FN_REMOVE_EVEN :
             (roll < 3) ? mhpq_pkg::FN_PEEK : mhpq_pkg::FN_REMOVE_MAX;
      end
      queue_op(f, rand_value());
   endtask

   // stimulus and end of run
   initial begin
      int n_rand;
      int len;
      int pct;

      // directed part: empty cases, extremes, even removal corners
      queue_op(mhpq_pkg::FN_PEEK, 32'h0);
      queue_op(mhpq_pkg::FN_REMOVE_MAX, 32'h1234_5678);
      queue_op(mhpq_pkg::FN_REMOVE_EVEN, 32'hffff_ffff);
      queue_op(mhpq_pkg::FN_INSERT, 32'h7fff_ffff);
      queue_op(mhpq_pkg::FN_INSERT, 32'h8000_0000);
      queue_op(mhpq_pkg::FN_INSERT, 32'h0000_0000);
      queue_op(mhpq_pkg::FN_INSERT, 32'hffff_ffff);
      queue_op(mhpq_pkg::FN_INSERT, 32'h0000_0001);
      queue_op(mhpq_pkg::FN_INSERT, 32'h0000_0002);
      queue_op(mhpq_pkg::FN_PEEK, 32'hdead_beef);
      queue_op(mhpq_pkg::FN_REMOVE_EVEN, 32'h0);
      queue_op(mhpq_pkg::FN_PEEK, 32'h0);
      queue_op(mhpq_pkg::FN_REMOVE_EVEN, 32'h0);       // nothing even left
      queue_op(mhpq_pkg::FN_REMOVE_MAX, 32'h0);
      queue_op(mhpq_pkg::FN_REMOVE_MAX, 32'h0);
      queue_op(mhpq_pkg::FN_REMOVE_MAX, 32'h0);
      queue_op(mhpq_pkg::FN_REMOVE_MAX, 32'h0);       // empty again
      queue_op(mhpq_pkg::FN_INSERT, 32'd5);
      queue_op(mhpq_pkg::FN_INSERT, 32'd5);
      queue_op(mhpq_pkg::FN_INSERT, 32'hffff_fffc);   // negative even
      queue_op(mhpq_pkg::FN_REMOVE_MAX, 32'h0);
      queue_op(mhpq_pkg::FN_REMOVE_EVEN, 32'h0);
      queue_op(mhpq_pkg::FN_PEEK, 32'h5555_aaaa);
      queue_op(mhpq_pkg::FN_REMOVE_MAX, 32'h0);

      // fill past capacity first so full rejects appear, then mixed phases
      n_rand = 0;
      for (int i = 0; i < 140; i++) begin
         queue_random(97, 1'b0);
         n_rand++;
      end
      while (n_rand < RANDOM_ITEMS) begin
         len = $urandom_range(30, 80);
         case ($urandom_range(0, 2))
            0: pct = 85;
            1: pct = 50;
            default: pct = 15;
         endcase
         for (int i = 0; (i < len) && (n_rand < RANDOM_ITEMS); i++) begin
            queue_random(pct, 1'b1);
            n_rand++;
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      wait (n_accepted == n_total);
      wait (expected_rsp.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (expected_rsp.size() > 0) begin
         n_errors++;
         $display("missing result: top %0h count %0d", expected_rsp[0].top,
                  expected_rsp[0].count);
         void'(expected_rsp.pop_front());
      end
      $display("covered %0d requests: %0d insert, %0d remove max, %0d remove even, %0d peek",
               n_accepted, op_seen[mhpq_pkg::FN_INSERT], op_seen[mhpq_pkg::FN_REMOVE_MAX],
               op_seen[mhpq_pkg::FN_REMOVE_EVEN], op_seen[mhpq_pkg::FN_PEEK]);
      $display("peak occupancy %0d, %0d full rejects, %0d empty removals, %0d mismatches",
               peak_count, n_full, n_empty, n_errors);
      if (n_errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d results outstanding", expected_rsp.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // sampling edge: predict on each request transaction, check each result
   always @(posedge clock) begin
      heap_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(predict_op(mhpq_pkg::func_type'(req_func), req_new_value));
            op_seen[req_func]++;
            n_accepted++;
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            rsp_taken = 1'b1;
            if (expected_rsp.size() == 0) begin
               n_errors++;
               $display("unexpected result %0d: top %0h count %0d", rsp_seen,
                        rsp_top_value, rsp_entry_count);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_top_value !== want.top)
                  report_mismatch("top_value", rsp_top_value, want.top);
               if (rsp_entry_count !== want.count)
                  report_mismatch("entry_count", 32'(rsp_entry_count), 32'(want.count));
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
            end
         end
      end
   end

   // request driver: random gap after each transaction, some stretches without gaps
   always @(negedge clock) begin
      heap_req_type item;
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_busy = 1'b0;
            req_wait = ((n_accepted / 40) % 4 == 3) ? 0 : $urandom_range(0, 8);
         end
         if (!req_busy) begin
            if (req_wait > 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               item = pending_ops.pop_front();
               req_func <= item.func;
               req_new_value <= item.value;
               req_valid <= 1'b1;
               req_busy = 1'b1;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // result receiver: random stall after each transaction, one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if (rsp_seen == HOLD_AT)
               rsp_wait = HOLD_CYCLES;
            else
               rsp_wait = ((rsp_seen / 50) % 4 == 1) ? 0 : $urandom_range(0, 8);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= 1'b0;
      end
   end

endmodule
